FILE: rtl/core/fpwc_pkg.sv
// Package: widths, codes and word types shared by the pending-work counter.
`timescale 1ns / 1ps
`default_nettype none
package fpwc_pkg;

  // Widths of the internal counters.
  localparam int COUNT_WIDTH = 16;
  localparam int SEQ_WIDTH   = 32;

  // Widths of the word fields on the ports.
  localparam int OP_W      = 3;
  localparam int SEQ_IN_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int ASSIGN_W  = 32;
  localparam int PENDING_W = 16;

  // A count of one means enabled and empty; zero means disabled.
  localparam logic [COUNT_WIDTH-1:0] EMPTY_MARK = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

  // One less than half of the sequence space: (2^N - 1) / 2, rounded down.
  localparam logic [SEQ_WIDTH-1:0] SEQ_HALF =
    SEQ_WIDTH'((64'd1 << (SEQ_WIDTH - 1)) - 64'd1);

  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH    = 3'd2;
  localparam logic [OP_W-1:0] OP_INIT     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEANUP  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SEQ_IN_W-1:0] seq_in;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ASSIGN_W-1:0]  seq_assigned;
    logic                 flush_done;
    logic [PENDING_W-1:0] pending_now;
  } rsp_word_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] pending_count;
    logic [COUNT_WIDTH-1:0] fence_count;
    logic [SEQ_WIDTH-1:0]   last_sequence;
    logic [SEQ_WIDTH-1:0]   fence_sequence;
  } ctr_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/fenced_pending_work_counter.sv
// Top level of the fenced pending-work counter: state and result registers.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+------------------------------
//   req     | in  | req_valid/req_ready  | operation, seq_in
//   rsp     | out | rsp_valid/rsp_ready  | status, seq_assigned,
//           |     |                      | flush_done, pending_now
//
// Every request word yields exactly one response word, registered at the
// edge that accepts it. The counter state updates at that same edge, so a
// new word can be taken every cycle while responses drain. The single
// response register sets the figure: a request is taken whenever that
// register is empty or is being drained in the same cycle. A stalled
// response holds the request side off. Reset clears the counters, leaving
// the block disabled until an init word, and empties the response register.
`timescale 1ns / 1ps
`default_nettype none
module fenced_pending_work_counter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire fpwc_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output fpwc_pkg::rsp_word_t      rsp
);

  fpwc_pkg::ctr_state_t state;
  fpwc_pkg::ctr_state_t state_next;
  fpwc_pkg::rsp_word_t  result;
  logic                 take;

  // The response register is free when empty or when its word leaves now.
  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;

  fpwc_step u_step (
    .state      (state),
    .req        (req),
    .state_next (state_next),
    .result     (result)
  );

  // Counter state advances only on an accepted request word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // The payload needs no reset; it is only looked at while rsp_valid is high.
  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= result;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request taken while a response is stalled");

  a_one_response: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request gave no response");

  a_disabled_no_fence: assert property (@(posedge clk) disable iff (rst)
    (state.pending_count == '0) |-> (state.fence_count == '0))
    else $error("fence count live while the counter is disabled");

  a_done_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.flush_done) |-> (rsp.status == fpwc_pkg::ST_OK))
    else $error("flush_done raised with a failing status");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/fpwc_step.sv
// Next-state and result logic for one operation of the pending-work counter.
`timescale 1ns / 1ps
`default_nettype none
module fpwc_step (
  input  wire fpwc_pkg::ctr_state_t state,
  input  wire fpwc_pkg::req_word_t  req,
  output fpwc_pkg::ctr_state_t      state_next,
  output fpwc_pkg::rsp_word_t       result
);

  logic [fpwc_pkg::SEQ_WIDTH-1:0]   seq;
  logic [fpwc_pkg::SEQ_WIDTH-1:0]   diff;
  logic [fpwc_pkg::COUNT_WIDTH-1:0] fence_dec;
  logic                             fence_open;

  assign seq        = req.seq_in[fpwc_pkg::SEQ_WIDTH-1:0];
  assign diff       = state.fence_sequence - seq;
  assign fence_dec  = state.fence_count - fpwc_pkg::EMPTY_MARK;
  assign fence_open = state.fence_count > fpwc_pkg::EMPTY_MARK;

  always_comb begin
    state_next          = state;
    result.status       = fpwc_pkg::ST_OK;
    result.seq_assigned = '0;
    result.flush_done   = 1'b0;
    unique case (req.operation)
      fpwc_pkg::OP_START: begin
        if (state.pending_count == '0) begin
          result.status = fpwc_pkg::ST_DENIED;
        end else if (state.pending_count == fpwc_pkg::COUNT_FULL) begin
          result.status = fpwc_pkg::ST_OVERFLOW;
        end else begin
          state_next.pending_count = state.pending_count + fpwc_pkg::EMPTY_MARK;
          state_next.last_sequence = state.last_sequence + fpwc_pkg::SEQ_WIDTH'(1);
          result.seq_assigned      = fpwc_pkg::ASSIGN_W'(state_next.last_sequence);
        end
      end
      fpwc_pkg::OP_COMPLETE: begin
        if (state.pending_count <= fpwc_pkg::EMPTY_MARK) begin
          result.status = fpwc_pkg::ST_DENIED;
        end else begin
          state_next.pending_count = state.pending_count - fpwc_pkg::EMPTY_MARK;
          // Only completions at or below the fence count toward the flush.
          if (fence_open && (diff < fpwc_pkg::SEQ_HALF)) begin
            state_next.fence_count = fence_dec;
            result.flush_done      = (fence_dec == fpwc_pkg::EMPTY_MARK);
          end
        end
      end
      fpwc_pkg::OP_FLUSH: begin
        if (state.pending_count == '0) begin
          result.status = fpwc_pkg::ST_DENIED;
        end else if (fence_open) begin
          result.status = fpwc_pkg::ST_BUSY;
        end else if (state.pending_count == fpwc_pkg::EMPTY_MARK) begin
          result.flush_done = 1'b1;
        end else begin
          state_next.fence_count    = state.pending_count;
          state_next.fence_sequence = state.last_sequence;
        end
      end
      fpwc_pkg::OP_INIT: begin
        state_next.pending_count = fpwc_pkg::EMPTY_MARK;
        state_next.fence_count   = fpwc_pkg::EMPTY_MARK;
        state_next.last_sequence = '0;
      end
      fpwc_pkg::OP_CLEANUP: begin
        if (state.pending_count != fpwc_pkg::EMPTY_MARK) begin
          result.status = fpwc_pkg::ST_DENIED;
        end else begin
          state_next.pending_count = '0;
          state_next.fence_count   = '0;
          state_next.last_sequence = '0;
        end
      end
      default: begin
      end
    endcase

    // Outstanding items after the operation; the disabled state reads as zero.
    result.pending_now = (state_next.pending_count == '0) ? '0 :
      fpwc_pkg::PENDING_W'(state_next.pending_count - fpwc_pkg::EMPTY_MARK);
  end

endmodule
`default_nettype wire

FILE: tb/fenced_pending_work_counter_tb.sv
// Self-checking testbench of the fenced pending-work counter, with directed and random traffic.
`timescale 1ns / 1ps
module fenced_pending_work_counter_tb;
  import fpwc_pkg::*;

  // Operation codes that the block treats as no-ops.
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  // Fence recorded by the directed drain test: four starts after init.
  localparam logic [SEQ_WIDTH-1:0] DRAIN_FENCE = 32'd4;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_word_t rsp;

  // While calm is set, neither the sender nor the receiver inserts idle cycles.
  bit calm = 1'b0;

  // Expected response words, oldest first.
  rsp_word_t awaited_rsp_q[$];

  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned flush_pulses  = 0;
  int unsigned fail_count    = 0;

  // Private copy of the counter state that the predictor walks forward.
  logic [COUNT_WIDTH-1:0] p_pending;
  logic [COUNT_WIDTH-1:0] p_fence;
  logic [SEQ_WIDTH-1:0]   p_last;
  logic [SEQ_WIDTH-1:0]   p_fence_seq;

  // Stimulus-side shadow of which sequence numbers are still outstanding.
  // It only steers the random traffic; it never decides pass or fail.
  bit                   gen_on;
  logic [SEQ_WIDTH-1:0] gen_last;
  logic [SEQ_WIDTH-1:0] live_q[$];

  fenced_pending_work_counter u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Advance the predicted counter state by one request word and return the
  // response word that the block must produce for it.
  function automatic rsp_word_t counter_response(input req_word_t w);
    rsp_word_t            r;
    logic [SEQ_WIDTH-1:0] distance;
    r = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_START: begin
        if (p_pending == '0) begin
          r.status = ST_DENIED;
        end else if (p_pending == COUNT_FULL) begin
          r.status = ST_OVERFLOW;
        end else begin
          p_pending      = p_pending + 1'b1;
          p_last         = p_last + 1'b1;
          r.seq_assigned = p_last;
        end
      end
      OP_COMPLETE: begin
        if (p_pending <= EMPTY_MARK) begin
          r.status = ST_DENIED;
        end else begin
          p_pending = p_pending - 1'b1;
          // Only a pending flush cares whether the item sits at or below the
          // fence; the difference is taken modulo the sequence space.
          if (p_fence > EMPTY_MARK) begin
            distance = p_fence_seq - w.seq_in;
            if (distance < SEQ_HALF) begin
              p_fence = p_fence - 1'b1;
              if (p_fence == EMPTY_MARK) r.flush_done = 1'b1;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (p_pending == '0) begin
          r.status = ST_DENIED;
        end else if (p_fence > EMPTY_MARK) begin
          r.status = ST_BUSY;
        end else if (p_pending == EMPTY_MARK) begin
          r.flush_done = 1'b1;
        end else begin
          p_fence     = p_pending;
          p_fence_seq = p_last;
        end
      end
      OP_INIT: begin
        p_pending = EMPTY_MARK;
        p_fence   = EMPTY_MARK;
        p_last    = '0;
      end
      OP_CLEANUP: begin
        if (p_pending != EMPTY_MARK) begin
          r.status = ST_DENIED;
        end else begin
          p_pending = '0;
          p_fence   = '0;
          p_last    = '0;
        end
      end
      default: begin
      end
    endcase
    r.pending_now = (p_pending == '0) ? '0 : PENDING_W'(p_pending - 1'b1);
    return r;
  endfunction

  // Both handshakes are observed at the rising edge, where the registered
  // outputs of the block still hold their values from before the edge. The
  // response is handled first, so a word taken at the same edge can never
  // be matched against the response that leaves at that edge.
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("response word with nothing expected: %h", rsp);
          fail_count++;
        end else begin
          want = awaited_rsp_q.pop_front();
          words_checked++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.seq_assigned !== want.seq_assigned) begin
            $error("seq_assigned: expected %h, got %h", want.seq_assigned, rsp.seq_assigned);
            fail_count++;
          end
          if (rsp.flush_done !== want.flush_done) begin
            $error("flush_done: expected %0d, got %0d", want.flush_done, rsp.flush_done);
            fail_count++;
          end
          if (rsp.pending_now !== want.pending_now) begin
            $error("pending_now: expected %0d, got %0d", want.pending_now, rsp.pending_now);
            fail_count++;
          end
          if (want.flush_done) flush_pulses++;
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp_q.push_back(counter_response(req));
        words_sent++;
      end
    end
  end

  // Receiver: ready is high by default and, unless calm is set, drops for bursts of random length.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < 12) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  // Present one request word and hold it until it is taken. Now and then the
  // sender goes idle for a burst first, so a gap can fall between any two words.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [SEQ_IN_W-1:0] seq);
    req_word_t w;
    w.operation = op;
    w.seq_in    = seq;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Stop sending and hold off until every expected response has arrived.
  task automatic wait_all_answered();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Out of reset the counter is disabled: everything but init is refused,
  // while the spare operation codes are quietly accepted.
  task automatic test_disabled_ops();
    send_word(OP_START, '0);
    send_word(OP_COMPLETE, '1);
    send_word(OP_FLUSH, $urandom());
    send_word(OP_CLEANUP, $urandom());
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
      send_word(OP_W'(op), $urandom());
    end
    send_word(OP_INIT, '0);
    // Cleanup of an empty, enabled counter disables it again.
    send_word(OP_CLEANUP, '1);
    send_word(OP_START, $urandom());
    send_word(OP_INIT, '1);
  endtask

  // A flush fence drained by completions on both sides of the wrap-safe
  // limit, a second flush refused, and a flush that finds nothing pending.
  task automatic test_fence_drain();
    send_word(OP_INIT, '0);
    repeat (4) send_word(OP_START, $urandom());
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, '0);
    // All ones lies just below the fence once the difference wraps.
    send_word(OP_COMPLETE, '1);
    // A distance of exactly SEQ_HALF counts as past the fence.
    send_word(OP_COMPLETE, DRAIN_FENCE - SEQ_HALF);
    send_word(OP_COMPLETE, 32'd2);
    // One less than SEQ_HALF is still at or below the fence.
    send_word(OP_COMPLETE, DRAIN_FENCE - (SEQ_HALF - 1'b1));
    // Counter is empty but the fence still waits for one item.
    send_word(OP_COMPLETE, DRAIN_FENCE);
    send_word(OP_START, $urandom());
    send_word(OP_COMPLETE, '0);
    send_word(OP_FLUSH, $urandom());
    // Init in the middle of a flush drops the fence but keeps its number.
    send_word(OP_START, $urandom());
    send_word(OP_FLUSH, $urandom());
    send_word(OP_INIT, $urandom());
    send_word(OP_START, $urandom());
    send_word(OP_CLEANUP, $urandom());
    send_word(OP_COMPLETE, 32'h5555_5555);
    send_word(OP_CLEANUP, $urandom());
    send_word(OP_INIT, $urandom());
  endtask

  // Mostly well-formed traffic: completions of numbers that are really
  // outstanding, flushes while work is in flight, drains down to cleanup.
  // The rest is refused work, stray numbers and spare codes.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned          roll;
    int unsigned          idx;
    logic [OP_W-1:0]      op;
    logic [SEQ_IN_W-1:0]  seq;
    send_word(OP_INIT, $urandom());
    gen_on   = 1'b1;
    gen_last = '0;
    live_q.delete();
    repeat (count) begin
      roll = $urandom_range(0, 99);
      seq  = $urandom();
      if (live_q.size() >= 48 && roll < 38) roll = 50;
      if (!gen_on) begin
        op = (roll < 80) ? OP_INIT : OP_W'($urandom_range(0, 7));
      end else if (roll < 38) begin
        op = OP_START;
      end else if (roll < 75) begin
        op = OP_COMPLETE;
      end else if (roll < 87) begin
        op = OP_FLUSH;
      end else if (roll < 90) begin
        op = OP_INIT;
      end else if (roll < 94) begin
        op = OP_CLEANUP;
      end else if (roll < 97) begin
        op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
        op = OP_W'($urandom_range(0, 7));
      end
      // Keep the shadow in step with what the block will do.
      case (op)
        OP_START: begin
          if (gen_on) begin
            gen_last = gen_last + 1'b1;
            live_q.push_back(gen_last);
          end
        end
        OP_COMPLETE: begin
          if (live_q.size() != 0) begin
            idx = $urandom_range(0, live_q.size() - 1);
            if ($urandom_range(0, 99) < 85) seq = live_q[idx];
            live_q.delete(idx);
          end
        end
        OP_INIT: begin
          gen_on   = 1'b1;
          gen_last = '0;
          live_q.delete();
        end
        OP_CLEANUP: begin
          if (live_q.size() == 0) gen_on = 1'b0;
        end
        default: begin
        end
      endcase
      send_word(op, seq);
      // Occasionally empty the counter completely so cleanup can succeed.
      if (gen_on && $urandom_range(0, 99) < 2) begin
        while (live_q.size() != 0) begin
          idx = $urandom_range(0, live_q.size() - 1);
          send_word(OP_COMPLETE, live_q[idx]);
          live_q.delete(idx);
        end
        if ($urandom_range(0, 1) == 0) begin
          send_word(OP_CLEANUP, $urandom());
          gen_on = 1'b0;
        end else begin
          send_word(OP_FLUSH, $urandom());
        end
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    p_pending   = '0;
    p_fence     = '0;
    p_last      = '0;
    p_fence_seq = '0;
    gen_on      = 1'b0;
    gen_last    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled_ops();
    test_fence_drain();
    test_random_traffic(400);
    wait_all_answered();
    test_random_traffic(300);
    // The closing stretch runs back to back on both sides.
    calm = 1'b1;
    test_random_traffic(150);

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    // Give any stray response time to show up.
    repeat (10) @(posedge clk);

    $display("Sent %0d request words and checked %0d response words, %0d with flush_done.",
             words_sent, words_checked, flush_pulses);
    $display("Covered disabled access, fence drain at the wrap limit and random traffic.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fpwc_pkg.sv
rtl/core/fpwc_step.sv
rtl/core/fenced_pending_work_counter.sv
tb/fenced_pending_work_counter_tb.sv
